### hdl/dlts_pkg.sv
// shared constants, types and helpers for the delta-list task timer
package dlts_pkg;

  localparam int MAX_TASKS   = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(MAX_TASKS);
  localparam int PTR_W       = $clog2(MAX_TASKS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [TIME_WIDTH-1:0] time_t;

  localparam ptr_t  NIL      = PTR_W'(MAX_TASKS);
  localparam time_t TIME_MAX = '1;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_ADDED    = 3'd0,
    STS_FULL     = 3'd1,
    STS_DELETED  = 3'd2,
    STS_BAD_SLOT = 3'd3,
    STS_TICKED   = 3'd4,
    STS_DUE      = 3'd5,
    STS_NONE_DUE = 3'd6
  } status_t;

  typedef enum logic {
    ALU_SUB     = 1'b0,
    ALU_ADD_SAT = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    time_t   a;
    time_t   b;
  } alu_req_t;

  typedef struct packed {
    time_t res;
    logic  borrow;
  } alu_rsp_t;

  // clamp a 32-bit input time to the time width
  function automatic time_t sat_time(logic [31:0] v);
    time_t r;
    if (v > 32'(TIME_MAX)) r = TIME_MAX;
    else r = TIME_WIDTH'(v);
    return r;
  endfunction

  // slot index carried by a list pointer
  function automatic idx_t pidx(ptr_t p);
    return p[IDX_W-1:0];
  endfunction

endpackage

### hdl/dlts_alu.sv
// shared time unit: subtract with borrow or saturating add
module dlts_alu (
  input  dlts_pkg::alu_req_t req,
  output dlts_pkg::alu_rsp_t rsp
);
  import dlts_pkg::*;

  logic [TIME_WIDTH:0] diff;
  logic [TIME_WIDTH:0] sum;

  assign diff = {1'b0, req.a} - {1'b0, req.b};
  assign sum  = {1'b0, req.a} + {1'b0, req.b};

  // select result by operation
  always_comb begin
    rsp.borrow = diff[TIME_WIDTH];
    case (req.op)
      ALU_SUB:     rsp.res = diff[TIME_WIDTH-1:0];
      ALU_ADD_SAT: rsp.res = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
      default:     rsp.res = diff[TIME_WIDTH-1:0];
    endcase
  end

endmodule

### hdl/delta_list_task_timer_scheduler_core.sv
// Delta-list task timer: one command at a time, walked by a small sequencer
// over a pool of task slots with one shared subtract/add unit. in_stall is
// high from the cycle after a command is taken until its last result has
// been loaded into the output register. Tick passes from its tick state to
// the finish state, as do the error cases; delete unlinks the slot in two
// steps; add walks the list past at most MAX_TASKS entries and then links;
// dispatch unlinks each due task and walks to re-insert a periodic one. The
// list walk goes one entry per cycle through the single delta read port. A
// stalled output only adds wait cycles. There is no clearing pass after reset.
module delta_list_task_timer_scheduler_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [31:0] in_first_delay,
  input  logic [31:0] in_repeat_period,
  input  logic [5:0] in_slot_sel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [5:0] out_slot_out,
  output logic       out_last
);
  import dlts_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_TICK  = 10'b0000000010,
    ST_ADD   = 10'b0000000100,
    ST_DEL   = 10'b0000001000,
    ST_CHK   = 10'b0000010000,
    ST_UNL_A = 10'b0000100000,
    ST_UNL_B = 10'b0001000000,
    ST_WALK  = 10'b0010000000,
    ST_LINK  = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_DEL = 2'd1,
    MODE_DSP = 2'd2
  } mode_t;

  // slot storage
  logic  used_r   [MAX_TASKS];
  ptr_t  next_r   [MAX_TASKS];
  ptr_t  prev_r   [MAX_TASKS];
  time_t period_r [MAX_TASKS];
  time_t delta_r  [MAX_TASKS];
  ptr_t  head_r, head_nxt;

  // sequencer registers
  state_t  state_r, state_nxt;
  mode_t   mode_r, mode_nxt;
  idx_t    s_r, s_nxt;
  ptr_t    cur_r, cur_nxt;
  ptr_t    before_r, before_nxt;
  ptr_t    guard_r, guard_nxt;
  time_t   t_r, t_nxt;
  time_t   tmp_r, tmp_nxt;
  time_t   period_in_r, period_in_nxt;
  logic [5:0] sel_r, sel_nxt;
  logic [RES_W-1:0] n_r, n_nxt;
  idx_t    pend_r, pend_nxt;
  status_t res_status_r, res_status_nxt;
  logic [5:0] res_slot_r, res_slot_nxt;

  // output register
  logic    out_valid_r;
  status_t out_status_r;
  logic [5:0] out_slot_r;
  logic    out_last_r;
  logic    emit;
  status_t emit_status;
  logic [5:0] emit_slot;
  logic    emit_last;
  logic    out_free;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  ptr_t  rd_ptr;
  time_t rd_delta;
  ptr_t  un_p, un_n;
  ptr_t  new_head;
  idx_t  free_idx;
  logic  pool_full;
  logic  walk_go;
  logic  dsp_cond;
  logic  dsp_emit;
  logic  sel_bad;

  dlts_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // lowest free slot
  always_comb begin
    free_idx  = '0;
    pool_full = 1'b1;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx  = IDX_W'(i);
        pool_full = 1'b0;
      end
    end
  end

  // unlink neighbors of the current slot
  assign un_p     = prev_r[s_r];
  assign un_n     = next_r[s_r];
  assign new_head = ((un_p < NIL) || (head_r != PTR_W'(s_r))) ? head_r : un_n;

  // single delta read port
  always_comb begin
    case (state_r)
      ST_TICK:  rd_ptr = head_r;
      ST_CHK:   rd_ptr = head_r;
      ST_UNL_A: rd_ptr = PTR_W'(s_r);
      ST_UNL_B: rd_ptr = un_n;
      ST_WALK:  rd_ptr = cur_r;
      ST_LINK:  rd_ptr = cur_r;
      default:  rd_ptr = head_r;
    endcase
  end
  assign rd_delta = delta_r[pidx(rd_ptr)];

  // operands of the shared unit
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = rd_delta;
    alu_req.b  = '0;
    case (state_r)
      ST_TICK:  alu_req.b = TIME_WIDTH'(1);
      ST_UNL_B: begin
        alu_req.op = ALU_ADD_SAT;
        alu_req.b  = tmp_r;
      end
      ST_WALK: begin
        alu_req.a = t_r;
        alu_req.b = rd_delta;
      end
      ST_LINK:  alu_req.b = t_r;
      default:  alu_req.b = '0;
    endcase
  end

  assign walk_go  = (cur_r < NIL) && !alu_rsp.borrow && (guard_r < NIL);
  assign dsp_cond = (n_r < RES_W'(MAX_RESULTS)) && (head_r < NIL) && (rd_delta == '0);
  assign dsp_emit = (n_r != '0) || !dsp_cond;
  assign sel_bad  = ({1'b0, sel_r} >= 7'(MAX_TASKS)) || !used_r[sel_r[IDX_W-1:0]];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    s_nxt          = s_r;
    cur_nxt        = cur_r;
    before_nxt     = before_r;
    guard_nxt      = guard_r;
    t_nxt          = t_r;
    tmp_nxt        = tmp_r;
    period_in_nxt  = period_in_r;
    sel_nxt        = sel_r;
    n_nxt          = n_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    head_nxt       = head_r;
    emit           = 1'b0;
    emit_status    = res_status_r;
    emit_slot      = res_slot_r;
    emit_last      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          t_nxt         = sat_time(in_first_delay);
          period_in_nxt = sat_time(in_repeat_period);
          sel_nxt       = in_slot_sel;
          n_nxt         = '0;
          case (cmd_t'(in_cmd))
            CMD_TICK:     state_nxt = ST_TICK;
            CMD_ADD:      state_nxt = ST_ADD;
            CMD_DELETE:   state_nxt = ST_DEL;
            CMD_DISPATCH: state_nxt = ST_CHK;
            default:      state_nxt = ST_TICK;
          endcase
        end
      end
      ST_TICK: begin
        res_status_nxt = STS_TICKED;
        res_slot_nxt   = '0;
        state_nxt      = ST_FIN;
      end
      ST_ADD: begin
        if (pool_full) begin
          res_status_nxt = STS_FULL;
          res_slot_nxt   = '0;
          state_nxt      = ST_FIN;
        end else begin
          s_nxt          = free_idx;
          cur_nxt        = head_r;
          before_nxt     = NIL;
          guard_nxt      = '0;
          mode_nxt       = MODE_ADD;
          res_status_nxt = STS_ADDED;
          res_slot_nxt   = 6'(free_idx);
          state_nxt      = ST_WALK;
        end
      end
      ST_DEL: begin
        res_slot_nxt = sel_r;
        if (sel_bad) begin
          res_status_nxt = STS_BAD_SLOT;
          state_nxt      = ST_FIN;
        end else begin
          res_status_nxt = STS_DELETED;
          s_nxt          = sel_r[IDX_W-1:0];
          mode_nxt       = MODE_DEL;
          state_nxt      = ST_UNL_A;
        end
      end
      ST_CHK: begin
        if (!dsp_emit || out_free) begin
          emit = dsp_emit;
          if (n_r != '0) begin
            emit_status = STS_DUE;
            emit_slot   = 6'(pend_r);
            emit_last   = !dsp_cond;
          end else begin
            emit_status = STS_NONE_DUE;
            emit_slot   = '0;
            emit_last   = 1'b1;
          end
          if (dsp_cond) begin
            s_nxt     = pidx(head_r);
            pend_nxt  = pidx(head_r);
            n_nxt     = n_r + RES_W'(1);
            mode_nxt  = MODE_DSP;
            state_nxt = ST_UNL_A;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_UNL_A: begin
        tmp_nxt   = rd_delta;
        state_nxt = ST_UNL_B;
      end
      ST_UNL_B: begin
        head_nxt = new_head;
        if (mode_r == MODE_DEL) begin
          state_nxt = ST_FIN;
        end else if (period_r[s_r] == '0) begin
          state_nxt = ST_CHK;
        end else begin
          t_nxt      = period_r[s_r];
          cur_nxt    = new_head;
          before_nxt = NIL;
          guard_nxt  = '0;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          t_nxt      = alu_rsp.res;
          before_nxt = cur_r;
          cur_nxt    = next_r[pidx(cur_r)];
          guard_nxt  = guard_r + PTR_W'(1);
        end else begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        if (!(before_r < NIL)) head_nxt = PTR_W'(s_r);
        state_nxt = (mode_r == MODE_DSP) ? ST_CHK : ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NIL;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      n_r     <= n_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    s_r          <= s_nxt;
    cur_r        <= cur_nxt;
    before_r     <= before_nxt;
    guard_r      <= guard_nxt;
    t_r          <= t_nxt;
    tmp_r        <= tmp_nxt;
    period_in_r  <= period_in_nxt;
    sel_r        <= sel_nxt;
    pend_r       <= pend_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_slot_r   <= emit_slot;
      out_last_r   <= emit_last;
    end
  end

  // list links and slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        used_r[i] <= 1'b0;
        next_r[i] <= NIL;
        prev_r[i] <= NIL;
      end
    end else begin
      case (state_r)
        ST_ADD: begin
          if (!pool_full) used_r[free_idx] <= 1'b1;
        end
        ST_UNL_B: begin
          if (un_n < NIL) prev_r[pidx(un_n)] <= un_p;
          if (un_p < NIL) next_r[pidx(un_p)] <= un_n;
          next_r[s_r] <= NIL;
          prev_r[s_r] <= NIL;
          if (mode_r == MODE_DEL || period_r[s_r] == '0) used_r[s_r] <= 1'b0;
        end
        ST_LINK: begin
          prev_r[s_r] <= before_r;
          next_r[s_r] <= cur_r;
          if (cur_r < NIL) prev_r[pidx(cur_r)] <= PTR_W'(s_r);
          if (before_r < NIL) next_r[pidx(before_r)] <= PTR_W'(s_r);
        end
        default: ;
      endcase
    end
  end

  // periods and deltas
  always_ff @(posedge clk) begin
    case (state_r)
      ST_ADD: begin
        if (!pool_full) period_r[free_idx] <= period_in_r;
      end
      ST_TICK: begin
        if ((head_r < NIL) && (rd_delta != '0)) delta_r[pidx(head_r)] <= alu_rsp.res;
      end
      ST_UNL_B: begin
        if (un_n < NIL) delta_r[pidx(un_n)] <= alu_rsp.res;
      end
      ST_LINK: begin
        delta_r[s_r] <= t_r;
        if (cur_r < NIL) delta_r[pidx(cur_r)] <= alu_rsp.res;
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  // a taken command always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("command transfer did not start the sequencer");

  // the list head is always an occupied slot
  a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r < NIL) |-> used_r[pidx(head_r)])
    else $error("list head points at a free slot");

  // dispatch never emits more than its result budget
  a_dsp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_W'(MAX_RESULTS))
    else $error("dispatch result count overran");

  // a result is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("pending result overwritten");
`endif

endmodule
